@@ rtl/idr_pkg.sv @@
// Package for the 64-bit divide/remainder unit: field widths, default data
// width and the sign/zero flags that travel down the divider pipeline.
// Depends on nothing; every other file of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package idr_pkg;

  // Width of the dividend, divisor, quotient and remainder fields on the ports.
  localparam int FIELD_W = 64;

  // Default operating width of the divider core.
  localparam int DATA_WIDTH_DEF = 64;

  // Sign and zero information carried alongside each division.
  typedef struct packed {
    logic num_neg;   // dividend was negative in signed mode
    logic den_neg;   // divisor was negative in signed mode
    logic den_zero;  // divisor is zero, result is forced to zero
  } idr_flags_t;

endpackage

`default_nettype wire

@@ rtl/idr_if.sv @@
// Request and response channel interfaces of the divide/remainder unit.
// Depends on idr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface idr_req_if
  import idr_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               is_signed;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, is_signed, dividend, divisor, input ready);
  modport sink   (input valid, is_signed, dividend, divisor, output ready);
endinterface

interface idr_rsp_if
  import idr_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;
  logic [FIELD_W-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);
endinterface

`default_nettype wire

@@ rtl/idr_prep.sv @@
// Entry stage: takes operand magnitudes and records signs and divide-by-zero.
// Depends on idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_prep
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  in_is_signed,
  input  logic [FIELD_W-1:0]    in_dividend,
  input  logic [FIELD_W-1:0]    in_divisor,
  output logic                  valid_r,
  output logic [DATA_WIDTH-1:0] part_r,
  output logic [DATA_WIDTH-1:0] nq_r,
  output logic [DATA_WIDTH-1:0] den_r,
  output idr_flags_t            flags_r
);

  logic [DATA_WIDTH-1:0] num;
  logic [DATA_WIDTH-1:0] den;
  idr_flags_t            flags_nxt;

  assign num = in_dividend[DATA_WIDTH-1:0];
  assign den = in_divisor[DATA_WIDTH-1:0];

  always_comb begin
    flags_nxt.num_neg  = in_is_signed & num[DATA_WIDTH-1];
    flags_nxt.den_neg  = in_is_signed & den[DATA_WIDTH-1];
    flags_nxt.den_zero = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r  <= '0;
      nq_r    <= flags_nxt.num_neg ? (DATA_WIDTH'(0) - num) : num;
      den_r   <= flags_nxt.den_neg ? (DATA_WIDTH'(0) - den) : den;
      flags_r <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/idr_step.sv @@
// One restoring shift-subtract iteration of the divider pipeline.
// The dividend register doubles as the quotient register. Depends on idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_step
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] part_i,
  input  logic [DATA_WIDTH-1:0] nq_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  input  idr_flags_t            flags_i,
  output logic                  valid_r,
  output logic [DATA_WIDTH-1:0] part_r,
  output logic [DATA_WIDTH-1:0] nq_r,
  output logic [DATA_WIDTH-1:0] den_r,
  output idr_flags_t            flags_r
);

  logic                  carry;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;

  // The partial remainder is effectively one bit wider: the bit shifted out
  // of the top forces a subtraction, and the low bits of the difference are
  // then exact.
  assign carry   = part_i[DATA_WIDTH-1];
  assign shifted = {part_i[DATA_WIDTH-2:0], nq_i[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {1'b0, den_i};
  assign take    = carry | ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r  <= take ? diff[DATA_WIDTH-1:0] : shifted;
      nq_r    <= {nq_i[DATA_WIDTH-2:0], take};
      den_r   <= den_i;
      flags_r <= flags_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/idr_post.sv @@
// Exit stage: restores the signs of quotient and remainder and forces a zero
// result for a zero divisor. Depends on idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_post
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] part_i,
  input  logic [DATA_WIDTH-1:0] nq_i,
  input  idr_flags_t            flags_i,
  output logic                  valid_r,
  output logic [DATA_WIDTH-1:0] quo_r,
  output logic [DATA_WIDTH-1:0] rem_r
);

  logic [DATA_WIDTH-1:0] quo_nxt;
  logic [DATA_WIDTH-1:0] rem_nxt;

  always_comb begin
    if (flags_i.den_zero) begin
      quo_nxt = '0;
      rem_nxt = '0;
    end else begin
      quo_nxt = (flags_i.num_neg ^ flags_i.den_neg) ? (DATA_WIDTH'(0) - nq_i) : nq_i;
      rem_nxt = flags_i.num_neg ? (DATA_WIDTH'(0) - part_i) : part_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/idr_outbuf.sv @@
// Two-entry output buffer that decouples the response channel from the
// pipeline and gives the pipeline its advance enable. Depends on idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idr_outbuf
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  output logic                  room,
  idr_rsp_if.source             out_rsp
);

  logic [DATA_WIDTH-1:0] quo_mem_r [0:1];
  logic [DATA_WIDTH-1:0] rem_mem_r [0:1];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            cnt_r;
  logic [1:0]            cnt_nxt;
  logic                  pop;

  assign room  = (cnt_r != 2'd2);
  assign pop   = out_rsp.valid & out_rsp.ready;

  assign out_rsp.valid     = (cnt_r != 2'd0);
  assign out_rsp.quotient  = FIELD_W'(quo_mem_r[rd_ptr_r]);
  assign out_rsp.remainder = FIELD_W'(rem_mem_r[rd_ptr_r]);

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      quo_mem_r[wr_ptr_r] <= quo_i;
      rem_mem_r[wr_ptr_r] <= rem_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/int64_divide_remainder_unit.sv @@
// Top level of the pipelined restoring divider: quotient and remainder of
// signed or unsigned DATA_WIDTH-bit operands. Depends on idr_pkg, idr_if,
// idr_prep, idr_step, idr_post and idr_outbuf.
//
//   Channel   Direction  Carries
//   in_req    sink       is_signed, dividend, divisor
//   out_rsp   source     quotient, remainder
//
// One request can enter per clock cycle while the pipeline advances. It passes
// an entry stage, DATA_WIDTH iteration stages (one quotient bit and one divisor
// subtract each) and an exit stage, and lands in the output buffer.
// Reset (rst_n, synchronous, active low) clears the valid bits and the buffer.
// The pipeline advances while the two-entry buffer has room; once stalled
// responses fill it, everything holds and in_req.ready drops until one leaves.
`timescale 1ns / 1ps
`default_nettype none

module int64_divide_remainder_unit
  import idr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  idr_req_if.sink   in_req,
  idr_rsp_if.source out_rsp
);

  // Pipeline enable: every stage moves when the output buffer can take one
  // more response. It depends only on registered buffer state.
  logic en;

  // Stage index 0 is the entry stage; index i + 1 holds the result of
  // iteration i.
  logic                  valid_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] part_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_s    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_s   [0:DATA_WIDTH];
  idr_flags_t            flags_s [0:DATA_WIDTH];

  logic                  post_valid;
  logic [DATA_WIDTH-1:0] post_quo;
  logic [DATA_WIDTH-1:0] post_rem;

  assign in_req.ready = en;

  idr_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_req.valid),
    .in_is_signed (in_req.is_signed),
    .in_dividend  (in_req.dividend),
    .in_divisor   (in_req.divisor),
    .valid_r      (valid_s[0]),
    .part_r       (part_s[0]),
    .nq_r         (nq_s[0]),
    .den_r        (den_s[0]),
    .flags_r      (flags_s[0])
  );

  // One stage per quotient bit, most significant bit first.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    idr_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_s[i]),
      .part_i  (part_s[i]),
      .nq_i    (nq_s[i]),
      .den_i   (den_s[i]),
      .flags_i (flags_s[i]),
      .valid_r (valid_s[i+1]),
      .part_r  (part_s[i+1]),
      .nq_r    (nq_s[i+1]),
      .den_r   (den_s[i+1]),
      .flags_r (flags_s[i+1])
    );
  end

  // After the last iteration the shift register holds the quotient magnitude
  // and the partial remainder holds the remainder magnitude.
  idr_post #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (valid_s[DATA_WIDTH]),
    .part_i  (part_s[DATA_WIDTH]),
    .nq_i    (nq_s[DATA_WIDTH]),
    .flags_i (flags_s[DATA_WIDTH]),
    .valid_r (post_valid),
    .quo_r   (post_quo),
    .rem_r   (post_rem)
  );

  // The buffer accepts the exit stage's response on every advance, so a
  // finished response can wait there while new requests keep entering.
  idr_outbuf #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (en & post_valid),
    .quo_i   (post_quo),
    .rem_i   (post_rem),
    .room    (en),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire
